/* design/wmg_pkg.sv */
// Shared types and constants for the 3x3 window morphology / gaussian filter.
// Used by the filter top level, front, queue and back end; depends on nothing.
package wmg_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WIN_N        = 9;
    localparam int SUM_W        = PIX_W + 4;
    localparam int DIV_SHIFT    = 4;

    localparam logic [PIX_W-1:0] PIX_FULL  = 8'hFF;
    localparam logic [PIX_W-1:0] DECAY_SET = 8'h80;

    // Left shift per window tap: weights 1 2 1 / 2 4 2 / 1 2 1
    localparam logic [1:0] GAUSS_SHL [WIN_N] = '{
        2'd0, 2'd1, 2'd0,
        2'd1, 2'd2, 2'd1,
        2'd0, 2'd1, 2'd0
    };

    typedef enum logic [1:0] {
        MODE_ERODE  = 2'd0,
        MODE_DILATE = 2'd1,
        MODE_GAUSS  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } cfg_t;

    // One classified window: taps indexed row * 3 + col, row 0 oldest
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] win;
        logic [PIX_W-1:0]            prior;
        logic [COL_W-1:0]            col;
        logic [ROW_W-1:0]            row;
    } qent_t;

endpackage

/* design/window3x3_morph_gauss_filter.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] pixel, tdata[15:8] prior_value
// m_axis    | out       | tdata[7:0] out_value, [17:8] out_col, [27:18] out_row, rest zero
// cfg write | in        | cfg_addr 0 filter_mode, 1 image_width, 2 image_height
//
// One pixel is taken every cycle while the queue has room; throughput is set by the single line store
// memory port pair (one read at accept, one write when the pixel leaves the first stage).
// The pixel that completes a window passes the first-stage registers, a queue entry and the result register.
// Reset is synchronous; line stores are not cleared and no clearing pass runs.
// Output stalls fill the two-entry queue before the input side is held.
//
// Top level: config registers and the front / queue / back chain; uses wmg_pkg.
module window3x3_morph_gauss_filter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [7:0] pixel, [15:8] prior_value
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [7:0] out_value, [17:8] out_col,
                                                 // [27:18] out_row, [31:28] zero
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_addr,
    input  logic [wmg_pkg::CFG_W-1:0] cfg_wdata
);

    wmg_pkg::cfg_t             cfg_reg;
    wmg_pkg::qent_t            push_data, pop_data;
    logic                      q_push, q_push_ready, q_pop, q_valid;
    logic [wmg_pkg::PIX_W-1:0] out_value;
    logic [wmg_pkg::COL_W-1:0] out_col;
    logic [wmg_pkg::ROW_W-1:0] out_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= wmg_pkg::MODE_ERODE;
            cfg_reg.width  <= wmg_pkg::CFG_W'(320);
            cfg_reg.height <= wmg_pkg::CFG_W'(240);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                wmg_pkg::REG_MODE:   cfg_reg.mode   <= cfg_wdata[1:0];
                wmg_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_wdata;
                wmg_pkg::REG_HEIGHT: cfg_reg.height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wmg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata[7:0]),
        .in_prior  (s_tdata[15:8]),
        .q_push    (q_push),
        .q_ready   (q_push_ready),
        .q_data    (push_data)
    );

    wmg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_data  (push_data),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (pop_data)
    );

    wmg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (cfg_reg.mode),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_col   (out_col),
        .out_row   (out_row)
    );

    assign m_tdata = {4'b0000, out_row, out_col, out_value};

endmodule

/* design/wmg_front.sv */
// Front end: raster counters, line store memory and 3x3 window register.
// Classifies each pixel and pushes interior windows into the queue; uses wmg_pkg.
module wmg_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wmg_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wmg_pkg::PIX_W-1:0]         in_pixel,
    input  logic [wmg_pkg::PIX_W-1:0]         in_prior,
    output logic                              q_push,
    input  logic                              q_ready,
    output wmg_pkg::qent_t                    q_data
);

    // Both line stores share one address: high byte row-2, low byte row-1
    logic [2*wmg_pkg::PIX_W-1:0] line_mem [wmg_pkg::MAX_WIDTH];
    logic [2*wmg_pkg::PIX_W-1:0] rd_reg;

    logic [wmg_pkg::COL_W-1:0] col_reg, col_next;
    logic [wmg_pkg::ROW_W-1:0] row_reg, row_next;

    logic                      s1_valid_reg;
    logic                      s1_emit_reg;
    logic [wmg_pkg::PIX_W-1:0] s1_pix_reg;
    logic [wmg_pkg::PIX_W-1:0] s1_prior_reg;
    logic [wmg_pkg::COL_W-1:0] s1_col_reg;
    logic [wmg_pkg::ROW_W-1:0] s1_row_reg;

    logic [wmg_pkg::WIN_N-1:0][wmg_pkg::PIX_W-1:0] win_reg, win_next;

    logic [wmg_pkg::CFG_W-1:0] w_clamp, h_clamp;
    logic [wmg_pkg::COL_W-1:0] col_last;
    logic [wmg_pkg::ROW_W-1:0] row_last;
    logic                      accept, s1_go;

    assign s1_go    = s1_valid_reg && (!s1_emit_reg || q_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    always_comb begin
        w_clamp = cfg.width;
        if (cfg.width < wmg_pkg::CFG_W'(3)) begin
            w_clamp = wmg_pkg::CFG_W'(3);
        end else if (cfg.width > wmg_pkg::CFG_W'(wmg_pkg::MAX_WIDTH)) begin
            w_clamp = wmg_pkg::CFG_W'(wmg_pkg::MAX_WIDTH);
        end
        h_clamp = cfg.height;
        if (cfg.height < wmg_pkg::CFG_W'(3)) begin
            h_clamp = wmg_pkg::CFG_W'(3);
        end else if (cfg.height > wmg_pkg::CFG_W'(wmg_pkg::HEIGHT_LIMIT)) begin
            h_clamp = wmg_pkg::CFG_W'(wmg_pkg::HEIGHT_LIMIT);
        end
        col_last = wmg_pkg::COL_W'(w_clamp - wmg_pkg::CFG_W'(1));
        row_last = wmg_pkg::ROW_W'(h_clamp - wmg_pkg::CFG_W'(1));
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg >= col_last) begin
                col_next = '0;
                row_next = (row_reg >= row_last) ? '0 : row_reg + wmg_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + wmg_pkg::COL_W'(1);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3+0] = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = rd_reg[2*wmg_pkg::PIX_W-1:wmg_pkg::PIX_W];
        win_next[5] = rd_reg[wmg_pkg::PIX_W-1:0];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go) begin
                win_reg <= win_next;
            end
        end
    end

    // Consecutive pixels never share a column, so read and write never collide
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg       <= line_mem[col_reg];
            s1_pix_reg   <= in_pixel;
            s1_prior_reg <= in_prior;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_emit_reg  <= (row_reg >= wmg_pkg::ROW_W'(2)) && (col_reg >= wmg_pkg::COL_W'(2));
        end
        if (s1_go) begin
            line_mem[s1_col_reg] <= {rd_reg[wmg_pkg::PIX_W-1:0], s1_pix_reg};
        end
    end

    assign q_push       = s1_go && s1_emit_reg;
    assign q_data.win   = win_next;
    assign q_data.prior = s1_prior_reg;
    assign q_data.col   = s1_col_reg - wmg_pkg::COL_W'(1);
    assign q_data.row   = s1_row_reg - wmg_pkg::ROW_W'(1);

endmodule

/* design/wmg_queue.sv */
// Two-entry queue between the front end and the filter back end.
// Holds classified windows so each side stalls on its own; uses wmg_pkg.
module wmg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    output logic           push_ready,
    input  wmg_pkg::qent_t push_data,
    input  logic           pop,
    output logic           pop_valid,
    output wmg_pkg::qent_t pop_data
);

    wmg_pkg::qent_t ent_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/wmg_back.sv */
// Back end: evaluates erode, layered dilate or gaussian on a queued window.
// Drives the registered result stage; uses wmg_pkg.
module wmg_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                mode,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  wmg_pkg::qent_t            q_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [wmg_pkg::PIX_W-1:0] out_value,
    output logic [wmg_pkg::COL_W-1:0] out_col,
    output logic [wmg_pkg::ROW_W-1:0] out_row
);

    logic                      out_valid_reg;
    logic [wmg_pkg::PIX_W-1:0] value_reg, value_next;
    logic [wmg_pkg::COL_W-1:0] col_reg;
    logic [wmg_pkg::ROW_W-1:0] row_reg;
    logic [wmg_pkg::SUM_W-1:0] sum;
    logic                      any_zero, any_set;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb begin
        sum      = '0;
        any_zero = 1'b0;
        any_set  = 1'b0;
        for (int k = 0; k < wmg_pkg::WIN_N; k++) begin
            if (q_data.win[k] == '0) begin
                any_zero = 1'b1;
            end else begin
                any_set = 1'b1;
            end
            sum = sum + (wmg_pkg::SUM_W'(q_data.win[k]) << wmg_pkg::GAUSS_SHL[k]);
        end
    end

    always_comb begin
        case (mode)
            wmg_pkg::MODE_ERODE: begin
                value_next = any_zero ? '0 : wmg_pkg::PIX_FULL;
            end
            wmg_pkg::MODE_DILATE: begin
                value_next = (q_data.prior >> 1) | (any_set ? wmg_pkg::DECAY_SET : '0);
            end
            default: begin
                // unused mode code falls through to gaussian
                value_next = sum[wmg_pkg::DIV_SHIFT +: wmg_pkg::PIX_W];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            value_reg <= value_next;
            col_reg   <= q_data.col;
            row_reg   <= q_data.row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = value_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;

endmodule

/* design/wmg_checker.sv */
// Port-level checks for the 3x3 window filter, bound to the top level.
// Sees only the top-level ports; uses nothing else.
module wmg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Centres are interior: column and row never zero
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:8] != 10'd0) && (m_tdata[27:18] != 10'd0))
        else $error("border centre reported");

    // Padding bits stay clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("tdata padding not zero");

endmodule

bind window3x3_morph_gauss_filter wmg_checker u_wmg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/window3x3_morph_gauss_filter_test.sv */
// Self-checking testbench for window3x3_morph_gauss_filter: stream driver, result monitor and
// a scoreboard that models the line stores, 3x3 window and erode / dilate / gaussian output.
// Depends on wmg_pkg and the filter top level only.
`timescale 1ns / 100ps

module window3x3_morph_gauss_filter_test;
    import wmg_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, behaves as gaussian
    localparam int         SETTLE_CYCLES = 8;
    localparam int         RANDOM_PIXELS = 180;

    typedef enum int {
        PIX_SPARSE,
        PIX_DENSE,
        PIX_UNIFORM,
        PIX_BINARY
    } pix_style_t;

    // Laid out as m_tdata, so a whole result compares in one go
    typedef struct packed {
        logic [3:0]       pad;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
    } centre_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_addr  = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    window3x3_morph_gauss_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Scoreboard copy of the filter state and its registers
    logic [1:0]       sb_mode   = MODE_ERODE;
    logic [CFG_W-1:0] sb_width  = 11'd320;
    logic [CFG_W-1:0] sb_height = 11'd240;
    logic [PIX_W-1:0] sb_line_prev  [MAX_WIDTH];
    logic [PIX_W-1:0] sb_line_older [MAX_WIDTH];
    logic [PIX_W-1:0] sb_win [WIN_N];
    logic [COL_W-1:0] sb_col = '0;
    logic [ROW_W-1:0] sb_row = '0;

    logic [15:0] pixel_q [$];      // {prior_value, pixel} waiting to be sent
    centre_t     due_centres [$];  // filtered centres still owed by the block

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int tx_gap    = 0;
    int rx_stall  = 0;

    int mismatches     = 0;
    int pixels_sent    = 0;
    int centres_seen   = 0;
    int reg_writes     = 0;
    int centres_in_mode [4] = '{0, 0, 0, 0};

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            sb_line_prev[i]  = '0;
            sb_line_older[i] = '0;
        end
        for (int k = 0; k < WIN_N; k++) sb_win[k] = '0;
    end

    function automatic int sat_dim(logic [CFG_W-1:0] raw, int limit);
        if (raw < 3) return 3;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // Raster position after one pixel: returns {row, col}
    function automatic logic [ROW_W+COL_W-1:0] next_pos(logic [COL_W-1:0] col,
                                                        logic [ROW_W-1:0] row,
                                                        int w, int h);
        if (col >= w - 1) begin
            if (row >= h - 1) return '0;
            return {row + 10'd1, 10'd0};
        end
        return {row, col + 10'd1};
    endfunction

    function automatic int pick_gap(bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] gen_pixel(pix_style_t style);
        int roll;
        roll = $urandom_range(0, 99);
        case (style)
            PIX_SPARSE:  return (roll < 88) ? 8'd0 : 8'($urandom_range(1, 255));
            PIX_DENSE:   return (roll < 6) ? 8'd0 : 8'($urandom_range(1, 255));
            PIX_BINARY:  return (roll < 15) ? 8'd0 : PIX_FULL;
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Shift the window, rotate the line stores and queue the centre if it is interior
    task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] prior);
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        int               weighted;
        bit               any_zero;
        bit               any_set;
        centre_t          c;
        top = sb_line_older[sb_col];
        mid = sb_line_prev[sb_col];
        sb_line_older[sb_col] = mid;
        sb_line_prev[sb_col]  = pix;
        for (int r = 0; r < 3; r++) begin
            sb_win[r*3]   = sb_win[r*3+1];
            sb_win[r*3+1] = sb_win[r*3+2];
        end
        sb_win[2] = top;
        sb_win[5] = mid;
        sb_win[8] = pix;
        if (sb_row >= 2 && sb_col >= 2) begin
            weighted = 0;
            any_zero = 1'b0;
            any_set  = 1'b0;
            for (int k = 0; k < WIN_N; k++) begin
                if (sb_win[k] == 0) any_zero = 1'b1;
                else any_set = 1'b1;
                weighted += sb_win[k] * (((k / 3) == 1) ? 2 : 1) * (((k % 3) == 1) ? 2 : 1);
            end
            c.pad = '0;
            c.col = sb_col - 10'd1;
            c.row = sb_row - 10'd1;
            if (sb_mode == MODE_ERODE)
                c.value = any_zero ? 8'd0 : PIX_FULL;
            else if (sb_mode == MODE_DILATE)
                c.value = (prior >> 1) | (any_set ? DECAY_SET : 8'd0);
            else
                c.value = 8'(weighted / 16);
            due_centres.push_back(c);
            centres_in_mode[sb_mode]++;
        end
        {sb_row, sb_col} = next_pos(sb_col, sb_row, sat_dim(sb_width, MAX_WIDTH),
                                    sat_dim(sb_height, HEIGHT_LIMIT));
    endtask

    // Driver: present the next pixel whenever the slot is free and no gap is running
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                filter_pixel(s_tdata[7:0], s_tdata[15:8]);
                pixels_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap = pick_gap(tx_steady);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest owed centre
    always @(posedge aclk) begin
        centre_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_centres.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: value %0d col %0d row %0d",
                                 $realtime, m_tdata[7:0], m_tdata[17:8], m_tdata[27:18]);
                end else begin
                    want = due_centres.pop_front();
                    centres_seen++;
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] mismatch: expected value %0d col %0d row %0d ",
                                      "pad %0h, got value %0d col %0d row %0d pad %0h"},
                                     $realtime, want.value, want.col, want.row, want.pad,
                                     m_tdata[7:0], m_tdata[17:8], m_tdata[27:18],
                                     m_tdata[31:28]);
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_steady);
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:   sb_mode   = val[1:0];
            REG_WIDTH:  sb_width  = val;
            REG_HEIGHT: sb_height = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Hold until every pixel is taken and every centre returned, then allow the pipe to drain
    task automatic settle();
        while (!(pixel_q.size() == 0 && !s_tvalid && due_centres.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic push_pixels(input int count, input pix_style_t style);
        @(negedge aclk);
        repeat (count) pixel_q.push_back({8'($urandom_range(0, 255)), gen_pixel(style)});
    endtask

    function automatic int pixels_to_frame_end();
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        int               n;
        col = sb_col;
        row = sb_row;
        n   = 0;
        do begin
            {row, col} = next_pos(col, row, sat_dim(sb_width, MAX_WIDTH),
                                  sat_dim(sb_height, HEIGHT_LIMIT));
            n++;
        end while (col != 0 || row != 0);
        return n;
    endfunction

    initial begin : main_seq
        int               random_pixels;
        int               n;
        int               w_now;
        int               roll;
        bit               at_start;
        logic [CFG_W-1:0] v;
        pix_style_t       style;

        random_pixels = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Three 3x3 frames: out-of-range sizes clamp to 3, one mode per frame
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd2);
        write_reg(REG_MODE, {9'd0, MODE_ERODE});
        @(negedge aclk);
        repeat (9) pixel_q.push_back({8'h00, PIX_FULL});
        settle();
        write_reg(REG_MODE, {9'd0, MODE_DILATE});
        @(negedge aclk);
        repeat (9) pixel_q.push_back({8'h00, 8'h00});
        settle();
        write_reg(REG_MODE, {9'h1FF, MODE_SPARE});
        @(negedge aclk);
        repeat (9) pixel_q.push_back({8'h00, PIX_FULL});
        settle();

        // Widest row, reached through saturation; narrow mid-frame so the frame ends early
        write_reg(REG_MODE, {9'd0, MODE_GAUSS});
        write_reg(REG_WIDTH, 11'h7FF);
        write_reg(REG_HEIGHT, 11'd0);
        push_pixels(MAX_WIDTH + 6, PIX_UNIFORM);
        settle();
        write_reg(REG_WIDTH, 11'd8);
        push_pixels(pixels_to_frame_end(), PIX_UNIFORM);
        settle();
        write_reg(REG_HEIGHT, 11'd5);

        while (random_pixels < RANDOM_PIXELS) begin
            at_start = (sb_col == 0 && sb_row == 0);
            w_now    = sat_dim(sb_width, MAX_WIDTH);
            if ($urandom_range(0, 2) == 0) begin
                v = 11'($urandom);
                case ($urandom_range(0, 3))
                    0:       v[1:0] = MODE_ERODE;
                    1:       v[1:0] = MODE_DILATE;
                    2:       v[1:0] = MODE_GAUSS;
                    default: v[1:0] = MODE_SPARE;
                endcase
                write_reg(REG_MODE, v);
            end
            // Widen only at a frame start; narrowing mid-frame never reads an unwritten column
            if (at_start && $urandom_range(0, 1) == 0) begin
                roll = $urandom_range(0, 19);
                if (roll < 2) write_reg(REG_WIDTH, 11'($urandom_range(0, 2)));
                else if (roll < 4) write_reg(REG_WIDTH, 11'($urandom_range(11, 40)));
                else write_reg(REG_WIDTH, 11'($urandom_range(3, 10)));
            end else if (!at_start && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(3, w_now);
                write_reg(REG_WIDTH, (n == 3) ? 11'($urandom_range(0, 3)) : 11'(n));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_HEIGHT, ($urandom_range(0, 3) == 0) ?
                          11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8)));

            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            style     = pix_style_t'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) n = pixels_to_frame_end();
            else n = $urandom_range(1, 3 * sat_dim(sb_width, MAX_WIDTH));
            push_pixels(n, style);
            settle();
            random_pixels += n;
        end

        $display("Sent %0d pixels over %0d register writes; checked %0d centres",
                 pixels_sent, reg_writes, centres_seen);
        $display("Centres by mode: erode %0d, dilate %0d, gaussian %0d, spare code %0d",
                 centres_in_mode[MODE_ERODE], centres_in_mode[MODE_DILATE],
                 centres_in_mode[MODE_GAUSS], centres_in_mode[MODE_SPARE]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timed out with %0d pixels queued and %0d centres owed",
                 pixel_q.size(), due_centres.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/wmg_pkg.sv
design/wmg_front.sv
design/wmg_queue.sv
design/wmg_back.sv
design/window3x3_morph_gauss_filter.sv
design/wmg_checker.sv
dv/window3x3_morph_gauss_filter_test.sv
